// ----- design/gated_multichannel_moving_average_macros.svh -----
// assertion helpers used by the checker file
`ifndef GATED_MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define GATED_MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// property checked on every rising edge outside reset
`define GMMA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property checked on every rising edge, reset included
`define GMMA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/gmma_pkg.sv -----
package gmma_pkg;

  // field widths
  localparam int SAMPLE_W  = 13;
  localparam int CHAN_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 1;

  // default geometry
  localparam int CHANNELS_DEF     = 5;
  localparam int BUFFER_DEPTH_DEF = 8;

  // limit register reset values, 1/16 degree units
  localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RST  = -13'sd2016;
  localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT_RST = 13'sd2960;

  // error counter saturation point
  localparam logic [COUNT_W-1:0] FAULT_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_GOOD       = 2'd0,
    STATUS_DISCONN    = 2'd1,
    STATUS_SENSOR_ERR = 2'd2,
    STATUS_BAD_CHAN   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = 1'b0,
    CFG_HIGH_LIMIT = 1'b1
  } cfg_idx_e;

  // classified request handed from the front end to the back end
  typedef struct packed {
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] sample;
    status_e                    status;
  } item_t;

endpackage

// ----- design/gmma_ram.sv -----
module gmma_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/gmma_front.sv -----
module gmma_front #(
  parameter int CHANNELS = gmma_pkg::CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [gmma_pkg::CHAN_W-1:0]          channel_i,
  input  logic signed [gmma_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 cfg_we_i,
  input  logic [gmma_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic signed [gmma_pkg::SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output gmma_pkg::item_t                      item_o
);

  import gmma_pkg::*;

  logic signed [SAMPLE_W-1:0] low_limit_q, low_limit_d;
  logic signed [SAMPLE_W-1:0] high_limit_q, high_limit_d;
  logic                       chan_ok;
  status_e                    status;

  // limit registers
  always_comb begin
    low_limit_d  = low_limit_q;
    high_limit_d = high_limit_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_LIMIT:  low_limit_d  = cfg_wdata_i;
        CFG_HIGH_LIMIT: high_limit_d = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= LOW_LIMIT_RST;
      high_limit_q <= HIGH_LIMIT_RST;
    end else begin
      low_limit_q  <= low_limit_d;
      high_limit_q <= high_limit_d;
    end
  end

  // classify the sample, disconnected wins over sensor error
  assign chan_ok = (32'(channel_i) < CHANNELS);

  always_comb begin
    priority if (!chan_ok) begin
      status = STATUS_BAD_CHAN;
    end else if (sample_i < low_limit_q) begin
      status = STATUS_DISCONN;
    end else if (sample_i >= high_limit_q) begin
      status = STATUS_SENSOR_ERR;
    end else begin
      status = STATUS_GOOD;
    end
  end

  // hand the request to the queue
  assign in_ready_o    = !full_i;
  assign push_o        = in_valid_i && !full_i;
  assign item_o.chan   = channel_i;
  assign item_o.sample = sample_i;
  assign item_o.status = status;

endmodule

// ----- design/gmma_queue.sv -----
module gmma_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gmma_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gmma_pkg::item_t item_o
);

  import gmma_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  item_t           slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // request storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

endmodule

// ----- design/gmma_back.sv -----
module gmma_back #(
  parameter int CHANNELS     = gmma_pkg::CHANNELS_DEF,
  parameter int BUFFER_DEPTH = gmma_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  gmma_pkg::item_t                      q_item_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [gmma_pkg::CHAN_W-1:0]          channel_out_o,
  output logic [gmma_pkg::STATUS_W-1:0]        status_o,
  output logic signed [gmma_pkg::SAMPLE_W-1:0] last_value_o,
  output logic signed [gmma_pkg::SAMPLE_W-1:0] average_o,
  output logic [gmma_pkg::COUNT_W-1:0]         error_count_o
);

  import gmma_pkg::*;

  localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ChxW  = (ChW > CHAN_W) ? ChW : CHAN_W;
  localparam int WpW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FillW = $clog2(BUFFER_DEPTH + 1);
  localparam int SumW  = SAMPLE_W + $clog2(BUFFER_DEPTH);
  localparam int CntW  = $clog2(SumW);
  localparam int AddrW = ChW + WpW;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  item_t  item_q;

  // per-channel state
  logic [WpW-1:0]             wp_q    [CHANNELS];
  logic [FillW-1:0]           fill_q  [CHANNELS];
  logic signed [SumW-1:0]     sum_q   [CHANNELS];
  logic signed [SAMPLE_W-1:0] good_q  [CHANNELS];
  logic [COUNT_W-1:0]         fault_q [CHANNELS];

  logic [ChxW-1:0]            chan_ext;
  logic [ChW-1:0]             cur_idx;
  logic [WpW-1:0]             wp_cur, wp_next;
  logic [FillW-1:0]           fill_cur, fill_good, fill_sel;
  logic signed [SumW-1:0]     sum_cur, sum_good, sum_sel;
  logic signed [SAMPLE_W-1:0] good_cur, old_sample;
  logic [COUNT_W-1:0]         fault_cur, fault_next;
  logic [SumW-1:0]            mag;
  logic                       is_good, buf_full;

  logic [AddrW-1:0]           ram_addr;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic                       ram_we;

  // divider
  logic [SumW-1:0]            quo_q, quo_next, quo_signed;
  logic [FillW-1:0]           rem_q, rem_next, div_q;
  logic [FillW:0]             trial, trial_diff;
  logic                       take, neg_q;
  logic [CntW-1:0]            cnt_q;

  // result registers
  logic [CHAN_W-1:0]          chan_out_q;
  status_e                    status_out_q;
  logic signed [SAMPLE_W-1:0] last_q, avg_q;
  logic [COUNT_W-1:0]         err_q;

  // channel being worked on
  assign chan_ext = ChxW'(item_q.chan);
  assign cur_idx  = (item_q.status == STATUS_BAD_CHAN) ? '0 : chan_ext[ChW-1:0];

  assign wp_cur    = wp_q[cur_idx];
  assign fill_cur  = fill_q[cur_idx];
  assign sum_cur   = sum_q[cur_idx];
  assign good_cur  = good_q[cur_idx];
  assign fault_cur = fault_q[cur_idx];

  // sample ring, one row per channel
  assign ram_addr = {cur_idx, wp_cur};
  assign ram_we   = (state_q == ST_UPDATE) && is_good;

  gmma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (1 << AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (item_q.sample),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // ring and counter update
  always_comb begin
    is_good    = (item_q.status == STATUS_GOOD);
    buf_full   = (fill_cur == FillW'(BUFFER_DEPTH));
    old_sample = buf_full ? ram_rdata : '0;
    sum_good   = sum_cur - SumW'(old_sample) + SumW'(item_q.sample);
    fill_good  = buf_full ? fill_cur : fill_cur + FillW'(1);
    wp_next    = (wp_cur == WpW'(BUFFER_DEPTH - 1)) ? '0 : wp_cur + WpW'(1);
    fault_next = (fault_cur == FAULT_MAX) ? fault_cur : fault_cur + COUNT_W'(1);
    sum_sel    = is_good ? sum_good : sum_cur;
    fill_sel   = is_good ? fill_good : fill_cur;
    mag        = sum_sel[SumW-1] ? SumW'(-sum_sel) : SumW'(sum_sel);
  end

  // restoring divide step, one quotient bit per cycle
  always_comb begin
    trial      = {rem_q, quo_q[SumW-1]};
    trial_diff = trial - {1'b0, div_q};
    take       = (trial >= {1'b0, div_q});
    rem_next   = take ? trial_diff[FillW-1:0] : trial[FillW-1:0];
    quo_next   = {quo_q[SumW-2:0], take};
    quo_signed = neg_q ? SumW'(-quo_next) : quo_next;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = (q_item_i.status == STATUS_BAD_CHAN) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = (fill_sel == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // per-channel registers, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp_q[i]    <= '0;
        fill_q[i]  <= '0;
        sum_q[i]   <= '0;
        good_q[i]  <= '0;
        fault_q[i] <= '0;
      end
    end else if (state_q == ST_UPDATE) begin
      if (is_good) begin
        wp_q[cur_idx]   <= wp_next;
        fill_q[cur_idx] <= fill_good;
        sum_q[cur_idx]  <= sum_good;
        good_q[cur_idx] <= item_q.sample;
      end else begin
        fault_q[cur_idx] <= fault_next;
      end
    end
  end

  // working request, divider and result registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q       <= q_item_i;
      chan_out_q   <= q_item_i.chan;
      status_out_q <= q_item_i.status;
      last_q       <= '0;
      avg_q        <= '0;
      err_q        <= '0;
    end
    if (state_q == ST_UPDATE) begin
      last_q <= is_good ? item_q.sample : good_cur;
      err_q  <= is_good ? fault_cur : fault_next;
      avg_q  <= '0;
      quo_q  <= mag;
      rem_q  <= '0;
      div_q  <= fill_sel;
      neg_q  <= sum_sel[SumW-1];
      cnt_q  <= CntW'(SumW - 1);
    end
    if (state_q == ST_DIV) begin
      quo_q <= quo_next;
      rem_q <= rem_next;
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        avg_q <= quo_signed[SAMPLE_W-1:0];
      end
    end
  end

  assign out_valid_o   = (state_q == ST_DONE);
  assign channel_out_o = chan_out_q;
  assign status_o      = status_out_q;
  assign last_value_o  = last_q;
  assign average_o     = avg_q;
  assign error_count_o = err_q;

endmodule

// ----- design/gated_multichannel_moving_average.sv -----
// Per-channel temperature filter. Each request carries a channel and a signed
// sample in 1/16 degree; the front end checks it against the two limit
// registers (below low_limit: disconnected, at or above high_limit: sensor
// error, channel past the last one: status 3 with zero fields) and drops it
// into a two-entry queue, so a new request is taken while the back end still
// works or holds a result. The back end reads the channel's ring slot from a
// sample RAM, updates the ring, running sum, last value and saturating error
// count, then divides the sum by the fill count with a restoring divider at
// one quotient bit per cycle (truncation toward zero, zero for an empty
// channel). A request passes ST_IDLE, ST_READ, ST_UPDATE, ST_DIV and ST_DONE;
// a bad channel goes from ST_IDLE straight to ST_DONE, and a fault on an
// empty channel skips ST_DIV. The per-channel registers clear at reset and
// the sample RAM has no clearing pass: a ring slot is only read back once
// the fill count shows it was written.
module gated_multichannel_moving_average #(
  parameter int CHANNELS     = gmma_pkg::CHANNELS_DEF,
  parameter int BUFFER_DEPTH = gmma_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [gmma_pkg::CHAN_W-1:0]          channel_i,
  input  logic signed [gmma_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [gmma_pkg::CHAN_W-1:0]          channel_out_o,
  output logic [gmma_pkg::STATUS_W-1:0]        status_o,
  output logic signed [gmma_pkg::SAMPLE_W-1:0] last_value_o,
  output logic signed [gmma_pkg::SAMPLE_W-1:0] average_o,
  output logic [gmma_pkg::COUNT_W-1:0]         error_count_o,
  input  logic                                 cfg_we_i,
  input  logic [gmma_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic signed [gmma_pkg::SAMPLE_W-1:0] cfg_wdata_i
);

  import gmma_pkg::*;

  item_t push_item, pop_item;
  logic  push, pop, q_full, q_valid;

  // classify and accept
  gmma_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // decoupling queue
  gmma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  // update, divide and hold the result
  gmma_back #(
    .CHANNELS     (CHANNELS),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_out_o (channel_out_o),
    .status_o      (status_o),
    .last_value_o  (last_value_o),
    .average_o     (average_o),
    .error_count_o (error_count_o)
  );

endmodule

// ----- design/gmma_checker.sv -----
`include "gated_multichannel_moving_average_macros.svh"

module gmma_checker #(
  parameter int CHANNELS = gmma_pkg::CHANNELS_DEF
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [gmma_pkg::CHAN_W-1:0]          channel_out_o,
  input logic [gmma_pkg::STATUS_W-1:0]        status_o,
  input logic signed [gmma_pkg::SAMPLE_W-1:0] last_value_o,
  input logic signed [gmma_pkg::SAMPLE_W-1:0] average_o,
  input logic [gmma_pkg::COUNT_W-1:0]         error_count_o
);

  import gmma_pkg::*;

  // no result shows while reset is applied
  `GMMA_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")

  // a waiting result stays up
  `GMMA_ASSERT(a_valid_holds, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")

  // a waiting result keeps its fields
  `GMMA_ASSERT(a_payload_holds, (out_valid_o && !out_ready_i) |=> ($stable(channel_out_o) && $stable(status_o) && $stable(last_value_o) && $stable(average_o) && $stable(error_count_o)), "result changed while stalled")

  // bad status exactly for channels past the last one
  `GMMA_ASSERT(a_bad_chan_status, out_valid_o |-> ((status_o == STATUS_BAD_CHAN) == (32'(channel_out_o) >= CHANNELS)), "channel range and status disagree")

  // a bad channel reports zero fields
  `GMMA_ASSERT(a_bad_chan_zero, (out_valid_o && (status_o == STATUS_BAD_CHAN)) |-> ((last_value_o == '0) && (average_o == '0) && (error_count_o == '0)), "bad channel with nonzero fields")

endmodule

bind gated_multichannel_moving_average gmma_checker #(
  .CHANNELS (CHANNELS)
) u_gmma_checker (.*);
